// ===== rtl/core/suid_pkg.sv =====
// shared constants, codes and control structs for the set union/intersect dedup engine
`default_nettype none

package suid_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int VALUE_W         = 32;
    localparam int FUNC_W          = 2;
    localparam int COUNT_OUT_W     = 7;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    // item function codes; the fourth code means nothing and is ignored
    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_LOAD   = 2'd1,
        FUNC_STREAM = 2'd2
    } func_t;

    localparam logic MODE_UNION     = 1'b0;
    localparam logic MODE_INTERSECT = 1'b1;

    // register index, taken from paddr above the byte offset
    localparam logic [APB_ADDR_W-3:0] REG_SET_MODE = '0;

    typedef struct packed {
        logic start;
        logic step;
        logic commit;
    } suid_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic cmp_pend;
        logic out_free;
    } suid_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/suid_if.sv =====
// valid/ready channel interfaces for input items and result items
`default_nettype none

interface suid_item_if;
    logic                              valid;
    logic                              ready;
    logic [suid_pkg::FUNC_W-1:0]       func;
    logic signed [suid_pkg::VALUE_W-1:0] elem_value;

    modport source (output valid, func, elem_value, input ready);
    modport sink   (input valid, func, elem_value, output ready);
endinterface

interface suid_res_if;
    logic                                valid;
    logic                                ready;
    logic                                emitted;
    logic signed [suid_pkg::VALUE_W-1:0] out_value;
    logic [suid_pkg::COUNT_OUT_W-1:0]    distinct_count;
    logic                                dropped_full;

    modport source (output valid, emitted, out_value, distinct_count, dropped_full,
                    input ready);
    modport sink   (input valid, emitted, out_value, distinct_count, dropped_full,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/set_union_intersect_dedup.sv =====
// top level of the streaming set union/intersect dedup engine
//
// channel   dir   handshake             payload
// item      in    valid/ready           func, elem_value
// result    out   valid/ready           emitted, out_value, distinct_count, dropped_full
// apb       in    psel/penable/pready   paddr, pwrite, pwdata -> prdata (set_mode at 0x0)
//
// scan: between acceptance and its result an item reads len entries, len being the filled
//   depth of the table(s) it must search
//   (filter count for a load, result count for a union stream, the larger of both for
//   an intersect stream, 0 for clear); the scan reads one ram entry per cycle from each
//   table ram
// the next item is accepted the cycle after the previous result is registered
// reset: asynchronous, clears counts and mode; table rams need no clearing pass
// stalls: a result waiting on the output register holds the engine in its commit step
`default_nettype none

module set_union_intersect_dedup #(
    parameter int TABLE_DEPTH = suid_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    suid_item_if.sink                                 item,
    suid_res_if.source                                result,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [suid_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [suid_pkg::APB_DATA_W-1:0]      pwdata,
    output logic      [suid_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                      pready
);

    logic                set_mode_reg;
    logic                cfg_hit;
    logic                item_ready;
    suid_pkg::suid_cmd_t cmd;
    suid_pkg::suid_sts_t sts;

    // config register decode, word addressed
    assign cfg_hit = (paddr[suid_pkg::APB_ADDR_W-1:2] == suid_pkg::REG_SET_MODE);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_mode_reg <= suid_pkg::MODE_UNION;
        end
        else if (psel && penable && pwrite && cfg_hit)
        begin
            set_mode_reg <= pwdata[0];
        end
    end

    assign prdata = cfg_hit ? {{(suid_pkg::APB_DATA_W-1){1'b0}}, set_mode_reg} : '0;

    // one transaction at a time: controller sequences, datapath searches and stores
    suid_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    assign item.ready = item_ready;

    suid_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .set_mode   (set_mode_reg),
        .func       (item.func),
        .elem_value (item.elem_value),
        .cmd        (cmd),
        .sts        (sts),
        .result     (result)
    );

endmodule

`default_nettype wire

// ===== rtl/core/suid_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none

module suid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/suid_ctrl.sv =====
// controller fsm: accept, scan the tables, commit the result
`default_nettype none

module suid_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire suid_pkg::suid_sts_t  sts,
    output suid_pkg::suid_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // issue reads until the span is covered, then let the last compare land
                if (!sts.scan_done)
                begin
                    cmd.step = 1'b1;
                end
                else if (!sts.cmp_pend)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/suid_dp.sv =====
// datapath: item registers, table rams, scan compare, counts and result register
`default_nettype none

module suid_dp #(
    parameter int TABLE_DEPTH = suid_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                set_mode,
    input  wire logic [suid_pkg::FUNC_W-1:0]         func,
    input  wire logic signed [suid_pkg::VALUE_W-1:0] elem_value,
    input  wire suid_pkg::suid_cmd_t                 cmd,
    output suid_pkg::suid_sts_t                      sts,
    suid_res_if.source                               result
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_W = suid_pkg::COUNT_OUT_W;
    localparam int VW    = suid_pkg::VALUE_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    logic [suid_pkg::FUNC_W-1:0] func_reg;
    logic [VW-1:0]               value_reg;
    logic                        mode_reg;
    logic [CNT_W-1:0]            len_reg;
    logic [CNT_W-1:0]            len_next;
    logic [CNT_W-1:0]            idx_reg;
    logic [CNT_W-1:0]            cmp_idx_reg;
    logic                        cmp_vld_reg;
    logic                        hit_r_reg;
    logic                        hit_f_reg;
    logic [CNT_W-1:0]            rcount_reg;
    logic [CNT_W-1:0]            rcount_next;
    logic [CNT_W-1:0]            fcount_reg;
    logic [CNT_W-1:0]            fcount_next;
    logic                        out_valid_reg;
    logic                        emitted_reg;
    logic                        emitted_next;
    logic [VW-1:0]               out_value_reg;
    logic [OUT_W-1:0]            count_out_reg;
    logic                        dropped_reg;
    logic                        dropped_next;
    logic                        r_we;
    logic                        f_we;
    logic                        wanted;
    logic [VW-1:0]               r_rdata;
    logic [VW-1:0]               f_rdata;
    logic [CNT_W+OUT_W-1:0]      count_ext;

    suid_ram #(.WIDTH(VW), .DEPTH(TABLE_DEPTH)) u_result_ram (
        .clk   (clk),
        .we    (cmd.commit && r_we),
        .waddr (rcount_reg[AW-1:0]),
        .wdata (value_reg),
        .raddr (idx_reg[AW-1:0]),
        .rdata (r_rdata)
    );

    suid_ram #(.WIDTH(VW), .DEPTH(TABLE_DEPTH)) u_filter_ram (
        .clk   (clk),
        .we    (cmd.commit && f_we),
        .waddr (fcount_reg[AW-1:0]),
        .wdata (value_reg),
        .raddr (idx_reg[AW-1:0]),
        .rdata (f_rdata)
    );

    // scan span: filled part of whichever tables the item must look at
    always_comb
    begin
        len_next = '0;
        unique case (func)
            suid_pkg::FUNC_LOAD:
            begin
                len_next = fcount_reg;
            end
            suid_pkg::FUNC_STREAM:
            begin
                if (set_mode == suid_pkg::MODE_INTERSECT && fcount_reg > rcount_reg)
                begin
                    len_next = fcount_reg;
                end
                else
                begin
                    len_next = rcount_reg;
                end
            end
            default:
            begin
                len_next = '0;
            end
        endcase
    end

    // payload and scan registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            func_reg  <= func;
            value_reg <= elem_value;
            mode_reg  <= set_mode;
            len_reg   <= len_next;
        end
        if (cmd.step)
        begin
            cmp_idx_reg <= idx_reg;
        end
        if (cmd.commit)
        begin
            emitted_reg   <= emitted_next;
            out_value_reg <= emitted_next ? value_reg : '0;
            count_out_reg <= count_ext[OUT_W-1:0];
            dropped_reg   <= dropped_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            hit_r_reg     <= 1'b0;
            hit_f_reg     <= 1'b0;
            rcount_reg    <= '0;
            fcount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= cmd.step;
            if (cmd.start)
            begin
                idx_reg   <= '0;
                hit_r_reg <= 1'b0;
                hit_f_reg <= 1'b0;
            end
            else
            begin
                if (cmd.step)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (cmp_vld_reg)
                begin
                    if (cmp_idx_reg < rcount_reg && r_rdata == value_reg)
                    begin
                        hit_r_reg <= 1'b1;
                    end
                    if (cmp_idx_reg < fcount_reg && f_rdata == value_reg)
                    begin
                        hit_f_reg <= 1'b1;
                    end
                end
            end
            if (cmd.commit)
            begin
                rcount_reg    <= rcount_next;
                fcount_reg    <= fcount_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // decision once the scan has finished
    always_comb
    begin
        rcount_next  = rcount_reg;
        fcount_next  = fcount_reg;
        r_we         = 1'b0;
        f_we         = 1'b0;
        emitted_next = 1'b0;
        dropped_next = 1'b0;
        wanted       = !hit_r_reg && (mode_reg == suid_pkg::MODE_UNION || hit_f_reg);
        unique case (func_reg)
            suid_pkg::FUNC_CLEAR:
            begin
                rcount_next = '0;
                fcount_next = '0;
            end
            suid_pkg::FUNC_LOAD:
            begin
                if (!hit_f_reg)
                begin
                    if (fcount_reg < DEPTH_C)
                    begin
                        f_we        = 1'b1;
                        fcount_next = fcount_reg + 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                end
            end
            suid_pkg::FUNC_STREAM:
            begin
                if (wanted)
                begin
                    if (rcount_reg < DEPTH_C)
                    begin
                        r_we         = 1'b1;
                        rcount_next  = rcount_reg + 1'b1;
                        emitted_next = 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                end
            end
            default:
            begin
                rcount_next = rcount_reg;
            end
        endcase
    end

    // reported count wraps at the output width
    assign count_ext = {{OUT_W{1'b0}}, rcount_next};

    assign sts.scan_done = (idx_reg == len_reg);
    assign sts.cmp_pend  = cmp_vld_reg;
    assign sts.out_free  = !out_valid_reg || result.ready;

    assign result.valid          = out_valid_reg;
    assign result.emitted        = emitted_reg;
    assign result.out_value      = $signed(out_value_reg);
    assign result.distinct_count = count_out_reg;
    assign result.dropped_full   = dropped_reg;

    a_rcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rcount_reg <= DEPTH_C)
        else $error("result count beyond table depth");

    a_fcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fcount_reg <= DEPTH_C)
        else $error("filter count beyond table depth");

    a_emit_not_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && emitted_reg |-> !dropped_reg)
        else $error("result both emitted and dropped");

    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> idx_reg < len_reg)
        else $error("table read past scan span");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// self-checking testbench for the streaming set union/intersect dedup engine
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = suid_pkg::TABLE_DEPTH_DEF;
    localparam int VALUE_W     = suid_pkg::VALUE_W;
    localparam int FUNC_W      = suid_pkg::FUNC_W;
    localparam int COUNT_OUT_W = suid_pkg::COUNT_OUT_W;
    localparam int APB_ADDR_W  = suid_pkg::APB_ADDR_W;
    localparam int APB_DATA_W  = suid_pkg::APB_DATA_W;
    // the fourth function code is not decoded by the block
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    // the slowest legal run is ~1950 items, each scanning up to a full table, plus stalls
    localparam int CYCLE_LIMIT = 2_000_000;
    // a full table scan plus pipeline, with margin
    localparam int DRAIN_CYCLES = DEPTH + 32;
    localparam int ITEM_GOAL = 1950;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [VALUE_W-1:0] value;
    } set_item_t;

    typedef struct packed {
        logic                        emitted;
        logic signed [VALUE_W-1:0]   out_value;
        logic [COUNT_OUT_W-1:0]      distinct_count;
        logic                        dropped_full;
    } set_result_t;

    logic clk = 1'b0;
    logic rst_n;

    // apb side, idle from time zero
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    suid_item_if item_ch();
    suid_res_if  res_ch();

    set_union_intersect_dedup #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch.sink),
        .result  (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 clk = ~clk;

    // items waiting to be offered, and results the predictor says must come back
    set_item_t   pending_items[$];
    set_result_t expected_results[$];

    // shadow of the block state used by the predictor
    logic [VALUE_W-1:0] result_vals[DEPTH];
    int unsigned        result_fill = 0;
    logic [VALUE_W-1:0] filter_vals[DEPTH];
    int unsigned        filter_fill = 0;
    logic               mode_setting = suid_pkg::MODE_UNION;

    bit          failed = 1'b0;
    bit          gap_free = 1'b0;    // set during the stretch with no idling
    int unsigned cycle_count = 0;
    int unsigned items_queued = 0;

    set_item_t   drv_item;
    set_result_t oldest_result;
    logic [VALUE_W-1:0] phase_vals[$];  // values used in the current sequence

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // linear search of the filled part of one shadow table
    function automatic bit holds(input bit in_filter, input logic [VALUE_W-1:0] v);
        int unsigned n;
        n = in_filter ? filter_fill : result_fill;
        for (int unsigned i = 0; i < n; i++)
        begin
            if ((in_filter ? filter_vals[i] : result_vals[i]) == v)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // apply one accepted item to the shadow state and queue its result
    task automatic predict_set_op(input logic [FUNC_W-1:0] fn, input logic [VALUE_W-1:0] v);
        set_result_t r;
        bit          wanted;
        r = '0;
        case (fn)
            suid_pkg::FUNC_CLEAR:
            begin
                result_fill = 0;
                filter_fill = 0;
            end
            suid_pkg::FUNC_LOAD:
            begin
                // loading works in either mode; repeats change nothing
                if (!holds(1'b1, v))
                begin
                    if (filter_fill < DEPTH)
                    begin
                        filter_vals[filter_fill] = v;
                        filter_fill++;
                    end
                    else
                        r.dropped_full = 1'b1;
                end
            end
            suid_pkg::FUNC_STREAM:
            begin
                wanted = !holds(1'b0, v);
                // union mode never looks at the filter
                if (mode_setting == suid_pkg::MODE_INTERSECT)
                    wanted = wanted && holds(1'b1, v);
                if (wanted)
                begin
                    if (result_fill < DEPTH)
                    begin
                        result_vals[result_fill] = v;
                        result_fill++;
                        r.emitted   = 1'b1;
                        r.out_value = v;
                    end
                    else
                        r.dropped_full = 1'b1;
                end
            end
            default: ;  // unused code leaves everything alone
        endcase
        r.distinct_count = COUNT_OUT_W'(result_fill);
        expected_results.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // driver: offers queued items, idling at random between transactions
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid      <= 1'b0;
            item_ch.func       <= suid_pkg::FUNC_CLEAR;
            item_ch.elem_value <= '0;
        end
        else if (!item_ch.valid || item_ch.ready)
        begin
            // previous transaction done (or none pending): pick the next or idle
            if (pending_items.size() != 0 && (gap_free || $urandom_range(99) >= 33))
            begin
                drv_item = pending_items.pop_front();
                item_ch.valid      <= 1'b1;
                item_ch.func       <= drv_item.func;
                item_ch.elem_value <= drv_item.value;
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    // result side backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= gap_free || ($urandom_range(99) >= 33);
    end

    // ------------------------------------------------------------------
    // monitor: predict on accepted items, check accepted results
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && item_ch.valid && item_ch.ready)
            predict_set_op(item_ch.func, item_ch.elem_value);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transaction: emitted %0d out_value %0d",
                       res_ch.emitted, res_ch.out_value);
                failed = 1'b1;
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                if (res_ch.emitted !== oldest_result.emitted)
                begin
                    $error("emitted: expected %0d, got %0d",
                           oldest_result.emitted, res_ch.emitted);
                    failed = 1'b1;
                end
                if (res_ch.out_value !== oldest_result.out_value)
                begin
                    $error("out_value: expected %0d, got %0d",
                           oldest_result.out_value, res_ch.out_value);
                    failed = 1'b1;
                end
                if (res_ch.distinct_count !== oldest_result.distinct_count)
                begin
                    $error("distinct_count: expected %0d, got %0d",
                           oldest_result.distinct_count, res_ch.distinct_count);
                    failed = 1'b1;
                end
                if (res_ch.dropped_full !== oldest_result.dropped_full)
                begin
                    $error("dropped_full: expected %0d, got %0d",
                           oldest_result.dropped_full, res_ch.dropped_full);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input logic [FUNC_W-1:0] fn, input logic [VALUE_W-1:0] v);
        set_item_t it;
        it.func  = fn;
        it.value = v;
        pending_items.push_back(it);
        if (fn != FUNC_UNUSED)
            items_queued++;
    endtask

    // idle means nothing queued, nothing offered and every result back;
    // checked at the falling edge so the rising-edge updates have settled
    task automatic wait_idle();
        @(negedge clk);
        while (pending_items.size() != 0 || item_ch.valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // one apb transaction: setup cycle, then access until pready
    task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] data,
                              output logic [APB_DATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {suid_pkg::REG_SET_MODE, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // mode write between sequences, with readback
    task automatic write_mode(input logic m);
        logic [APB_DATA_W-1:0] rd;
        wait_idle();
        apb_access(1'b1, APB_DATA_W'(m), rd);
        mode_setting = m;
        apb_access(1'b0, '0, rd);
        if (rd !== APB_DATA_W'(m))
        begin
            $error("set_mode readback: expected %0d, got %0d", m, rd);
            failed = 1'b1;
        end
    endtask

    // value mix: extremes, a narrow band that repeats often, full-range noise
    function automatic logic [VALUE_W-1:0] rand_elem(input bit spread);
        if (spread && $urandom_range(9) != 0)
            return $urandom;
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3, 4, 5: return VALUE_W'($urandom_range(15)) - 32'd8;
            default: return $urandom;
        endcase
    endfunction

    // either reuse a value of this sequence (duplicates, filter hits) or a fresh one
    function automatic logic [VALUE_W-1:0] seq_elem(input bit spread, input int reuse_pct);
        logic [VALUE_W-1:0] v;
        if (phase_vals.size() != 0 && $urandom_range(99) < reuse_pct)
            v = phase_vals[$urandom_range(phase_vals.size() - 1)];
        else
            v = rand_elem(spread);
        phase_vals.push_back(v);
        return v;
    endfunction

    // one random sequence under a random mode
    task automatic run_sequence(input bit long_run);
        int n_load;
        int n_strm;
        bit spread;
        write_mode($urandom_range(1));
        phase_vals.delete();
        if (long_run || $urandom_range(9) < 8)
        begin
            // well-formed: clear, load the second set, stream the first set;
            // skipping the clear sometimes keeps the tables across a mode change
            spread = long_run || ($urandom_range(7) == 0);
            if ($urandom_range(4) != 0)
                push_item(suid_pkg::FUNC_CLEAR, rand_elem(1'b0));
            n_load = spread ? $urandom_range(60, 72) : $urandom_range(0, 20);
            n_strm = spread ? $urandom_range(66, 80) : $urandom_range(1, 25);
            for (int i = 0; i < n_load; i++)
                push_item(suid_pkg::FUNC_LOAD, seq_elem(spread, spread ? 5 : 25));
            for (int i = 0; i < n_strm; i++)
            begin
                if ($urandom_range(39) == 0)
                    push_item(FUNC_UNUSED, $urandom);
                push_item(suid_pkg::FUNC_STREAM, seq_elem(spread, 50));
            end
        end
        else
        begin
            // noise: any code, any order
            n_strm = $urandom_range(10, 30);
            for (int i = 0; i < n_strm; i++)
                push_item(FUNC_W'($urandom_range(3)), seq_elem(1'b0, 30));
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int seq_idx;
        seq_idx = 0;
        // x to 0 counts as an edge, so every driver enters reset at time zero
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed, union mode from reset: extremes, a duplicate, filter ignored,
        // unused code, clear lets a value join again
        push_item(suid_pkg::FUNC_STREAM, 32'h8000_0000);
        push_item(suid_pkg::FUNC_STREAM, 32'h7fff_ffff);
        push_item(suid_pkg::FUNC_STREAM, 32'h0000_0000);
        push_item(suid_pkg::FUNC_STREAM, 32'hffff_ffff);
        push_item(suid_pkg::FUNC_STREAM, 32'h7fff_ffff);
        push_item(suid_pkg::FUNC_LOAD,   32'h0000_0005);
        push_item(suid_pkg::FUNC_STREAM, 32'h0000_0005);
        push_item(FUNC_UNUSED,           32'hdead_beef);
        push_item(suid_pkg::FUNC_CLEAR,  32'hffff_ffff);
        push_item(suid_pkg::FUNC_STREAM, 32'h7fff_ffff);

        // directed, intersect mode: repeated load, hit, duplicate hit, miss,
        // clear empties the filter too
        write_mode(suid_pkg::MODE_INTERSECT);
        push_item(suid_pkg::FUNC_LOAD,   32'h8000_0000);
        push_item(suid_pkg::FUNC_LOAD,   32'h8000_0000);
        push_item(suid_pkg::FUNC_LOAD,   32'h0000_002a);
        push_item(suid_pkg::FUNC_STREAM, 32'h0000_002a);
        push_item(suid_pkg::FUNC_STREAM, 32'h0000_002a);
        push_item(suid_pkg::FUNC_STREAM, 32'h0000_002b);
        push_item(suid_pkg::FUNC_STREAM, 32'h8000_0000);
        push_item(FUNC_UNUSED,           32'h7fff_ffff);
        push_item(suid_pkg::FUNC_CLEAR,  32'h0000_0000);
        push_item(suid_pkg::FUNC_STREAM, 32'h0000_002a);

        // mode change with tables kept
        write_mode(suid_pkg::MODE_UNION);
        push_item(suid_pkg::FUNC_STREAM, 32'h0000_0001);

        // random sequences; one long stretch runs with no idling on either side
        while (items_queued < ITEM_GOAL)
        begin
            if (seq_idx == 4)
            begin
                wait_idle();
                gap_free = 1'b1;
                run_sequence(1'b1);
                wait_idle();
                gap_free = 1'b0;
            end
            else
                run_sequence(1'b0);
            seq_idx++;
        end

        wait_idle();
        // let any stray result show up
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            failed = 1'b1;
        end
        if (!failed)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
